// File: hw/rtl/mpa_pkg.sv
package mpa_pkg;

  // residue width and field widths
  localparam int unsigned RES_W  = 31;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned CNT_W  = 5;

  // prime 2^31 - 2^27 + 1 and Montgomery constants for R = 2^31
  localparam logic [RES_W-1:0] MOD_P    = 31'd2013265921;
  localparam logic [RES_W-1:0] R_MOD_P  = 31'd134217727;
  localparam logic [RES_W-1:0] R2_MOD_P = 31'd796358521;
  localparam logic [RES_W-1:0] ONE      = 31'd1;
  localparam logic [RES_W-1:0] P_MINUS2 = 31'd2013265919;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_ADD  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SUB  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MUL  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TOM  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FROM = 3'd4;
  localparam logic [KIND_W-1:0] KIND_POW  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_INV  = 3'd6;

  // one conditional subtract brings a 31-bit value below P
  function automatic logic [RES_W-1:0] fold(input logic [RES_W-1:0] v);
    logic [RES_W-1:0] r;
    r = (v >= MOD_P) ? (v - MOD_P) : v;
    return r;
  endfunction

endpackage

// File: hw/rtl/mpa_mont_mul.sv
module mpa_mont_mul
  import mpa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [RES_W-1:0] x,
  input  logic [RES_W-1:0] y,
  output logic             done,
  output logic [RES_W-1:0] result
);

  logic [RES_W-1:0] a_sh;
  logic [RES_W-1:0] b_r;
  logic [RES_W:0]   s;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic             fin;
  logic [RES_W+1:0] t;
  logic [RES_W+1:0] u;
  logic [RES_W:0]   s_next;

  // one radix-2 step: add b when the multiplier bit is set, make even with P, halve
  always_comb begin
    t = {1'b0, s} + (a_sh[0] ? {2'b00, b_r} : '0);
    u = t + (t[0] ? {2'b00, MOD_P} : '0);
    s_next = u[RES_W+1:1];
  end

  // step counter and accumulator; s stays below 2P
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // done pulses in the cycle after the final correction
      done <= !start && !run && fin;
      if (start) begin
        a_sh <= x;
        b_r  <= y;
        s    <= '0;
        cnt  <= '0;
        run  <= 1'b1;
      end else if (run) begin
        s    <= s_next;
        a_sh <= a_sh >> 1;
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(RES_W - 1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        // final correction below P
        if (s >= {1'b0, MOD_P}) begin
          result <= RES_W'(s - {1'b0, MOD_P});
        end else begin
          result <= s[RES_W-1:0];
        end
      end
    end
  end

  a_run_cnt: assert property (@(posedge clk) disable iff (rst)
    run |-> (cnt < CNT_W'(RES_W))) else $error("step count overrun");
  a_start_run: assert property (@(posedge clk) disable iff (rst)
    start |=> run) else $error("multiply did not start");
  a_done_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result < MOD_P)) else $error("product not reduced");
  a_fin_done: assert property (@(posedge clk) disable iff (rst)
    (fin && !start) |=> done) else $error("missing done after final step");

endmodule

// File: hw/rtl/montgomery_mod_prime_alu_top.sv
// Modular arithmetic unit for P = 2^31 - 2^27 + 1 in Montgomery form, R = 2^31.
// Input channel: item_valid / item_stall with kind, operand_a, operand_b and
// exponent. Output channel: result_valid / result_stall with residue_out.
// An item is taken when valid is high and stall is low; each item yields one
// result. One item is worked on at a time; item_stall is high from accept
// until the result has been moved into the output register.
// Work per item, set by the bit-serial Montgomery multiplier (31 steps plus one
// correction per product):
//   add, sub, unused kind: no product
//   multiply, to/from Montgomery form: one product
//   power: a square for each of the 31 exponent bits plus a multiply per set bit
//   invert: power by P-2
// The output register holds a finished result while result_stall is high; the
// next item is accepted meanwhile and, once done, waits until that register frees.
// Synchronous reset returns to idle with no result pending.
module montgomery_mod_prime_alu_top
  import mpa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [KIND_W-1:0] kind,
  input  logic [RES_W-1:0]  operand_a,
  input  logic [RES_W-1:0]  operand_b,
  input  logic [RES_W-1:0]  exponent,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [RES_W-1:0]  residue_out
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_SQ    = 3'd3;
  localparam logic [2:0] S_PM    = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]        state;
  logic [KIND_W-1:0] kind_r;
  logic [RES_W-1:0]  a_r;
  logic [RES_W-1:0]  b_r;
  logic [RES_W-1:0]  exp_r;
  logic [CNT_W-1:0]  bit_cnt;
  logic [RES_W-1:0]  res;
  logic              mm_start;
  logic [RES_W-1:0]  mm_x;
  logic [RES_W-1:0]  mm_y;
  logic              mm_done;
  logic [RES_W-1:0]  mm_res;
  logic [RES_W:0]    sum;
  logic [RES_W:0]    diff;
  logic [RES_W-1:0]  add_res;
  logic [RES_W-1:0]  sub_res;
  logic              last_bit;

  assign item_stall = rst || (state != S_IDLE);
  assign last_bit   = (bit_cnt == CNT_W'(RES_W - 1));

  // add and subtract with one correction each
  always_comb begin
    sum  = {1'b0, a_r} + {1'b0, b_r};
    diff = (a_r >= b_r) ? ({1'b0, a_r} - {1'b0, b_r})
                        : ({1'b0, a_r} + {1'b0, MOD_P} - {1'b0, b_r});
    add_res = (sum >= {1'b0, MOD_P}) ? RES_W'(sum - {1'b0, MOD_P}) : sum[RES_W-1:0];
    sub_res = diff[RES_W-1:0];
  end

  mpa_mont_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mm_start),
    .x      (mm_x),
    .y      (mm_y),
    .done   (mm_done),
    .result (mm_res)
  );

  // sequencer: square-and-multiply walks the exponent from its top bit
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      mm_start     <= 1'b0;
      result_valid <= 1'b0;
      bit_cnt      <= '0;
    end else begin
      // output taken with nothing new to load
      if (result_valid && !result_stall && (state != S_DONE)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          mm_start <= 1'b0;
          if (item_valid) begin
            kind_r <= kind;
            a_r    <= fold(operand_a);
            b_r    <= fold(operand_b);
            exp_r  <= (kind == KIND_INV) ? P_MINUS2 : exponent;
            state  <= S_START;
          end
        end
        S_START: begin
          case (kind_r)
            KIND_ADD: begin
              mm_start <= 1'b0;
              res      <= add_res;
              state    <= S_DONE;
            end
            KIND_SUB: begin
              mm_start <= 1'b0;
              res      <= sub_res;
              state    <= S_DONE;
            end
            KIND_MUL: begin
              mm_start <= 1'b1;
              mm_x     <= a_r;
              mm_y     <= b_r;
              state    <= S_MUL;
            end
            KIND_TOM: begin
              mm_start <= 1'b1;
              mm_x     <= a_r;
              mm_y     <= R2_MOD_P;
              state    <= S_MUL;
            end
            KIND_FROM: begin
              mm_start <= 1'b1;
              mm_x     <= a_r;
              mm_y     <= ONE;
              state    <= S_MUL;
            end
            KIND_POW, KIND_INV: begin
              mm_start <= 1'b1;
              mm_x     <= R_MOD_P;
              mm_y     <= R_MOD_P;
              bit_cnt  <= '0;
              state    <= S_SQ;
            end
            default: begin
              mm_start <= 1'b0;
              res      <= '0;
              state    <= S_DONE;
            end
          endcase
        end
        S_MUL: begin
          mm_start <= 1'b0;
          if (mm_done) begin
            res   <= mm_res;
            state <= S_DONE;
          end
        end
        S_SQ: begin
          if (mm_done) begin
            if (exp_r[RES_W-1]) begin
              mm_start <= 1'b1;
              mm_x     <= mm_res;
              mm_y     <= a_r;
              state    <= S_PM;
            end else if (last_bit) begin
              mm_start <= 1'b0;
              res      <= mm_res;
              state    <= S_DONE;
            end else begin
              mm_start <= 1'b1;
              mm_x     <= mm_res;
              mm_y     <= mm_res;
              exp_r    <= exp_r << 1;
              bit_cnt  <= bit_cnt + 1'b1;
            end
          end else begin
            mm_start <= 1'b0;
          end
        end
        S_PM: begin
          if (mm_done) begin
            if (last_bit) begin
              mm_start <= 1'b0;
              res      <= mm_res;
              state    <= S_DONE;
            end else begin
              mm_start <= 1'b1;
              mm_x     <= mm_res;
              mm_y     <= mm_res;
              exp_r    <= exp_r << 1;
              bit_cnt  <= bit_cnt + 1'b1;
              state    <= S_SQ;
            end
          end else begin
            mm_start <= 1'b0;
          end
        end
        S_DONE: begin
          mm_start <= 1'b0;
          // move into the output register once it is free
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            residue_out  <= res;
            state        <= S_IDLE;
          end
        end
        default: begin
          mm_start <= 1'b0;
          state    <= S_IDLE;
        end
      endcase
    end
  end

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (residue_out < MOD_P)) else $error("result not reduced");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall) else $error("second item taken");
  a_done_state: assert property (@(posedge clk) disable iff (rst)
    mm_done |-> (state == S_MUL || state == S_SQ || state == S_PM))
    else $error("product finished with no waiting operation");
  a_bit_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQ || state == S_PM) |-> (bit_cnt < CNT_W'(RES_W)))
    else $error("exponent bit count overrun");

endmodule
